### design/dpr_pkg.sv
// shared types and constants for the depth-to-point reprojection block
`timescale 1ns / 1ps

package dpr_pkg;

	// register index codes
	localparam logic [2:0] REG_OUT_WIDTH    = 3'd0;
	localparam logic [2:0] REG_OUT_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_STEP         = 3'd2;
	localparam logic [2:0] REG_MIN_DEPTH_MM = 3'd3;
	localparam logic [2:0] REG_MAX_DEPTH_MM = 3'd4;
	localparam logic [2:0] REG_INV_FOCAL_X  = 3'd5;
	localparam logic [2:0] REG_INV_FOCAL_Y  = 3'd6;

	// configuration register widths and limits
	localparam int CfgDataW  = 25;
	localparam int SizeW     = 13;
	localparam int StepW     = 5;
	localparam int DepthW    = 16;
	localparam int InvW      = 25;
	localparam int IndexW    = 12;
	localparam int PhaseW    = 4;
	localparam int HalfW     = 14;
	localparam int MagW      = 13;
	localparam int Prod1W    = MagW + DepthW;
	localparam int Prod2W    = Prod1W + InvW;
	localparam int FracShift = 21;

	localparam logic [SizeW-1:0] MaxOutWidth  = 13'd4096;
	localparam logic [SizeW-1:0] MaxOutHeight = 13'd4096;
	localparam logic [StepW-1:0] MaxStep      = 5'd16;

	// reset values of the registers
	localparam logic [SizeW-1:0]  RstOutWidth  = 13'd320;
	localparam logic [SizeW-1:0]  RstOutHeight = 13'd200;
	localparam logic [StepW-1:0]  RstStep      = 5'd2;
	localparam logic [DepthW-1:0] RstMinDepth  = 16'd10;
	localparam logic [DepthW-1:0] RstMaxDepth  = 16'd2000;
	localparam logic [InvW-1:0]   RstInvFocal  = 25'd67109;

	// queue depth between front and back
	localparam int QueueDepth = 4;
	localparam int QPtrW      = 2;
	localparam int QCntW      = 3;

	// one classified pixel waiting for the back end
	typedef struct packed {
		logic signed [HalfW-1:0] hx;
		logic signed [HalfW-1:0] hy;
		logic [DepthW-1:0]       depth;
		logic                    point_valid;
		logic                    frame_end;
	} dpr_entry_t;

endpackage

### design/dpr_front.sv
// front end: raster position counters, downsample and depth range classification
`timescale 1ns / 1ps

module dpr_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [dpr_pkg::DepthW-1:0]            depth_mm,
	input  logic                                  frame_start,
	input  logic [dpr_pkg::SizeW-1:0]             out_width,
	input  logic [dpr_pkg::SizeW-1:0]             out_height,
	input  logic [dpr_pkg::StepW-1:0]             step,
	input  logic [dpr_pkg::DepthW-1:0]            min_depth_mm,
	input  logic [dpr_pkg::DepthW-1:0]            max_depth_mm,
	input  logic                                  queue_full,
	output logic                                  push,
	output dpr_pkg::dpr_entry_t                   push_entry
);

	logic [dpr_pkg::PhaseW-1:0] column_phase_q, row_phase_q;
	logic [dpr_pkg::IndexW-1:0] column_index_q, row_index_q;
	logic [dpr_pkg::PhaseW-1:0] col_ph, row_ph;
	logic [dpr_pkg::IndexW-1:0] col_idx, row_idx;
	logic [dpr_pkg::SizeW-1:0]  w_c, h_c;
	logic [dpr_pkg::StepW-1:0]  s_c, s_m1;
	logic col_last_ph, col_last, row_last_ph, row_last;
	logic kept, in_range, valid, last, accept;

	// clamp the frame geometry to the supported range
	always_comb begin
		w_c = out_width;
		if (out_width == '0) w_c = dpr_pkg::SizeW'(1);
		else if (out_width > dpr_pkg::MaxOutWidth) w_c = dpr_pkg::MaxOutWidth;
		h_c = out_height;
		if (out_height == '0) h_c = dpr_pkg::SizeW'(1);
		else if (out_height > dpr_pkg::MaxOutHeight) h_c = dpr_pkg::MaxOutHeight;
		s_c = step;
		if (step == '0) s_c = dpr_pkg::StepW'(1);
		else if (step > dpr_pkg::MaxStep) s_c = dpr_pkg::MaxStep;
		s_m1 = s_c - dpr_pkg::StepW'(1);
	end

	// current position, restarted by frame_start
	assign col_ph  = frame_start ? '0 : column_phase_q;
	assign row_ph  = frame_start ? '0 : row_phase_q;
	assign col_idx = frame_start ? '0 : column_index_q;
	assign row_idx = frame_start ? '0 : row_index_q;

	// classification of the pixel
	assign col_last_ph = {1'b0, col_ph} >= s_m1;
	assign row_last_ph = {1'b0, row_ph} >= s_m1;
	assign col_last    = {1'b0, col_idx} >= (w_c - dpr_pkg::SizeW'(1));
	assign row_last    = {1'b0, row_idx} >= (h_c - dpr_pkg::SizeW'(1));
	assign last        = col_last_ph & col_last & row_last_ph & row_last;
	assign kept        = (col_ph == '0) && (row_ph == '0);
	assign in_range    = (depth_mm > min_depth_mm) && (depth_mm < max_depth_mm);
	assign valid       = kept & in_range;

	assign in_ready = !queue_full;
	assign accept   = in_valid & in_ready;
	assign push     = accept & (valid | last);

	// half-pixel offsets from the centre
	always_comb begin
		push_entry.hx = $signed({1'b0, col_idx, 1'b0}) - $signed({1'b0, w_c});
		push_entry.hy = $signed({1'b0, row_idx, 1'b0}) - $signed({1'b0, h_c});
		push_entry.depth       = depth_mm;
		push_entry.point_valid = valid;
		push_entry.frame_end   = last;
	end

	// raster position advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_phase_q <= '0;
			column_index_q <= '0;
			row_phase_q    <= '0;
			row_index_q    <= '0;
		end else if (accept) begin
			column_phase_q <= col_ph;
			column_index_q <= col_idx;
			row_phase_q    <= row_ph;
			row_index_q    <= row_idx;
			if (!col_last_ph) begin
				column_phase_q <= col_ph + dpr_pkg::PhaseW'(1);
			end else begin
				column_phase_q <= '0;
				if (!col_last) begin
					column_index_q <= col_idx + dpr_pkg::IndexW'(1);
				end else begin
					column_index_q <= '0;
					if (!row_last_ph) begin
						row_phase_q <= row_ph + dpr_pkg::PhaseW'(1);
					end else begin
						row_phase_q <= '0;
						if (!row_last) row_index_q <= row_idx + dpr_pkg::IndexW'(1);
						else row_index_q <= '0;
					end
				end
			end
		end
	end

endmodule

### design/dpr_queue.sv
// small register queue between the front and back ends
`timescale 1ns / 1ps

module dpr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dpr_pkg::dpr_entry_t push_entry,
	input  logic                pop,
	output dpr_pkg::dpr_entry_t pop_entry,
	output logic                full,
	output logic                empty
);

	dpr_pkg::dpr_entry_t entries_q [dpr_pkg::QueueDepth];
	logic [dpr_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [dpr_pkg::QCntW-1:0] count_q;
	logic do_push, do_pop;

	assign full    = count_q == dpr_pkg::QCntW'(dpr_pkg::QueueDepth);
	assign empty   = count_q == '0;
	assign do_push = push & !full;
	assign do_pop  = pop & !empty;
	assign pop_entry = entries_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + dpr_pkg::QPtrW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + dpr_pkg::QPtrW'(1);
			if (do_push && !do_pop) count_q <= count_q + dpr_pkg::QCntW'(1);
			else if (do_pop && !do_push) count_q <= count_q - dpr_pkg::QCntW'(1);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) entries_q[wr_ptr_q] <= push_entry;
	end

endmodule

### design/dpr_back.sv
// back end: sequenced back-projection multiplies, rounding and output register
`timescale 1ns / 1ps

module dpr_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                queue_empty,
	input  dpr_pkg::dpr_entry_t                 pop_entry,
	output logic                                pop,
	input  logic [dpr_pkg::InvW-1:0]            inv_focal_x,
	input  logic [dpr_pkg::InvW-1:0]            inv_focal_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [31:0]                  x_sixteenth_mm,
	output logic signed [31:0]                  y_sixteenth_mm,
	output logic [dpr_pkg::DepthW-1:0]          z_mm,
	output logic                                point_valid,
	output logic                                frame_end
);

	typedef enum logic [1:0] {S_IDLE, S_MUL, S_SCALE, S_FIN} state_t;

	state_t                      state_q;
	dpr_pkg::dpr_entry_t         entry_q;
	logic [dpr_pkg::Prod1W-1:0]  px_q, py_q;
	logic [dpr_pkg::Prod2W-1:0]  qx_q, qy_q;
	logic [dpr_pkg::MagW-1:0]    mag_x, mag_y;
	logic [dpr_pkg::HalfW-1:0]   abs_x, abs_y;
	logic [31:0]                 res_x, res_y;
	logic                        out_valid_q, load_out;

	// floor of the scaled product with signed saturation
	function automatic logic [31:0] dpr_round(input logic [dpr_pkg::Prod2W-1:0] prod,
			input logic neg);
		logic [dpr_pkg::Prod2W:0]                 sum;
		logic [dpr_pkg::Prod2W-dpr_pkg::FracShift:0] q;
		logic [31:0]                              r;
		sum = {1'b0, prod} + (dpr_pkg::Prod2W+1)'({dpr_pkg::FracShift{1'b1}});
		if (!neg) begin
			q = (dpr_pkg::Prod2W-dpr_pkg::FracShift+1)'(prod >> dpr_pkg::FracShift);
			if (q > (dpr_pkg::Prod2W-dpr_pkg::FracShift+1)'(32'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
			else r = q[31:0];
		end else begin
			q = sum[dpr_pkg::Prod2W:dpr_pkg::FracShift];
			if (q > (dpr_pkg::Prod2W-dpr_pkg::FracShift+1)'(33'h1_0000_0000 >> 1))
				r = 32'h8000_0000;
			else r = 32'd0 - q[31:0];
		end
		return r;
	endfunction

	// magnitudes of the half-pixel offsets
	assign abs_x = entry_q.hx[dpr_pkg::HalfW-1] ? -entry_q.hx : entry_q.hx;
	assign abs_y = entry_q.hy[dpr_pkg::HalfW-1] ? -entry_q.hy : entry_q.hy;
	assign mag_x = abs_x[dpr_pkg::MagW-1:0];
	assign mag_y = abs_y[dpr_pkg::MagW-1:0];

	assign res_x = dpr_round(qx_q, entry_q.hx[dpr_pkg::HalfW-1]);
	assign res_y = dpr_round(qy_q, entry_q.hy[dpr_pkg::HalfW-1]);

	assign pop      = (state_q == S_IDLE) && !queue_empty;
	assign load_out = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// sequencer, datapath registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			entry_q        <= '0;
			px_q           <= '0;
			py_q           <= '0;
			qx_q           <= '0;
			qy_q           <= '0;
			out_valid_q    <= 1'b0;
			x_sixteenth_mm <= '0;
			y_sixteenth_mm <= '0;
			z_mm           <= '0;
			point_valid    <= 1'b0;
			frame_end      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (!queue_empty) begin
						entry_q <= pop_entry;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					px_q    <= {{dpr_pkg::DepthW{1'b0}}, mag_x}
						* {{dpr_pkg::MagW{1'b0}}, entry_q.depth};
					py_q    <= {{dpr_pkg::DepthW{1'b0}}, mag_y}
						* {{dpr_pkg::MagW{1'b0}}, entry_q.depth};
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					qx_q    <= {{dpr_pkg::InvW{1'b0}}, px_q}
						* {{dpr_pkg::Prod1W{1'b0}}, inv_focal_x};
					qy_q    <= {{dpr_pkg::InvW{1'b0}}, py_q}
						* {{dpr_pkg::Prod1W{1'b0}}, inv_focal_y};
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (load_out) begin
						out_valid_q    <= 1'b1;
						x_sixteenth_mm <= entry_q.point_valid ? $signed(res_x) : '0;
						y_sixteenth_mm <= entry_q.point_valid ? $signed(res_y) : '0;
						z_mm           <= entry_q.point_valid ? entry_q.depth : '0;
						point_valid    <= entry_q.point_valid;
						frame_end      <= entry_q.frame_end;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### design/depth_to_point_reprojection_top.sv
// top level of the depth-to-point reprojection block: registers and wiring
`timescale 1ns / 1ps

// Raw depth pixels in raster order are taken one per cycle while the four-entry
// queue between the front end and the back end has room. Pixels that are
// dropped by downsampling or the depth limits are not queued; each
// pixel that yields a result (a kept in-range point or the frame's last pixel)
// occupies the back end through the steps of its sequencer: fetch from the
// queue, depth multiply, focal multiply, then rounding into the output
// register. The back end fetches the next entry only once the last one has
// reached the output register. Results leave through that register, so the
// back end can fetch and multiply the next entry while a result waits.
// Configuration is written by index and takes effect at once.

module depth_to_point_reprojection_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [2:0]                          cfg_index,
	input  logic [dpr_pkg::CfgDataW-1:0]        cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dpr_pkg::DepthW-1:0]          depth_mm,
	input  logic                                frame_start,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [31:0]                  x_sixteenth_mm,
	output logic signed [31:0]                  y_sixteenth_mm,
	output logic [dpr_pkg::DepthW-1:0]          z_mm,
	output logic                                point_valid,
	output logic                                frame_end
);

	logic [dpr_pkg::SizeW-1:0]  out_width_q, out_height_q;
	logic [dpr_pkg::StepW-1:0]  step_q;
	logic [dpr_pkg::DepthW-1:0] min_depth_q, max_depth_q;
	logic [dpr_pkg::InvW-1:0]   inv_focal_x_q, inv_focal_y_q;
	logic                       push, pop, q_full, q_empty;
	dpr_pkg::dpr_entry_t        push_entry, pop_entry;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_width_q   <= dpr_pkg::RstOutWidth;
			out_height_q  <= dpr_pkg::RstOutHeight;
			step_q        <= dpr_pkg::RstStep;
			min_depth_q   <= dpr_pkg::RstMinDepth;
			max_depth_q   <= dpr_pkg::RstMaxDepth;
			inv_focal_x_q <= dpr_pkg::RstInvFocal;
			inv_focal_y_q <= dpr_pkg::RstInvFocal;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dpr_pkg::REG_OUT_WIDTH:    out_width_q   <= cfg_data[dpr_pkg::SizeW-1:0];
				dpr_pkg::REG_OUT_HEIGHT:   out_height_q  <= cfg_data[dpr_pkg::SizeW-1:0];
				dpr_pkg::REG_STEP:         step_q        <= cfg_data[dpr_pkg::StepW-1:0];
				dpr_pkg::REG_MIN_DEPTH_MM: min_depth_q   <= cfg_data[dpr_pkg::DepthW-1:0];
				dpr_pkg::REG_MAX_DEPTH_MM: max_depth_q   <= cfg_data[dpr_pkg::DepthW-1:0];
				dpr_pkg::REG_INV_FOCAL_X:  inv_focal_x_q <= cfg_data[dpr_pkg::InvW-1:0];
				dpr_pkg::REG_INV_FOCAL_Y:  inv_focal_y_q <= cfg_data[dpr_pkg::InvW-1:0];
				default: ;
			endcase
		end
	end

	// pixel classification
	dpr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.depth_mm     (depth_mm),
		.frame_start  (frame_start),
		.out_width    (out_width_q),
		.out_height   (out_height_q),
		.step         (step_q),
		.min_depth_mm (min_depth_q),
		.max_depth_mm (max_depth_q),
		.queue_full   (q_full),
		.push         (push),
		.push_entry   (push_entry)
	);

	// decoupling queue
	dpr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.full       (q_full),
		.empty      (q_empty)
	);

	// back-projection
	dpr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.queue_empty    (q_empty),
		.pop_entry      (pop_entry),
		.pop            (pop),
		.inv_focal_x    (inv_focal_x_q),
		.inv_focal_y    (inv_focal_y_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.x_sixteenth_mm (x_sixteenth_mm),
		.y_sixteenth_mm (y_sixteenth_mm),
		.z_mm           (z_mm),
		.point_valid    (point_valid),
		.frame_end      (frame_end)
	);

endmodule

### verif/depth_to_point_reprojection_top_tb.sv
// testbench for the depth-to-point reprojection block: raster pixel stimulus and point checks
`timescale 1ns / 1ps

module depth_to_point_reprojection_top_tb;

	localparam int DRAIN_CYCLES        = 40;
	localparam int RAND_PHASES         = 8;
	localparam int RAND_ITEMS_PER_PHASE = 100;
	localparam int WIDE_ROW_PIXELS     = 240;
	localparam longint TIMEOUT_NS      = 64'd8_000_000;

	typedef struct packed {
		logic [dpr_pkg::DepthW-1:0] depth;
		logic                       start;
	} pixel_t;

	typedef struct packed {
		logic signed [31:0]         x;
		logic signed [31:0]         y;
		logic [dpr_pkg::DepthW-1:0] z;
		logic                       point_valid;
		logic                       frame_end;
	} point_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [2:0]                    cfg_index = dpr_pkg::REG_OUT_WIDTH;
	logic [dpr_pkg::CfgDataW-1:0]  cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [dpr_pkg::DepthW-1:0]    depth_mm = '0;
	logic                          frame_start = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [31:0]            x_sixteenth_mm;
	logic signed [31:0]            y_sixteenth_mm;
	logic [dpr_pkg::DepthW-1:0]    z_mm;
	logic                          point_valid;
	logic                          frame_end;

	// pixels waiting to be driven and points waiting to come out
	pixel_t pixel_q[$];
	point_t pending_points[$];
	logic   pixel_taken = 1'b0;
	int     gap_pct = 0;
	int     stall_pct = 0;
	int     mismatch_count = 0;

	// register copies as the block should hold them
	logic [dpr_pkg::SizeW-1:0]  cur_out_width  = dpr_pkg::RstOutWidth;
	logic [dpr_pkg::SizeW-1:0]  cur_out_height = dpr_pkg::RstOutHeight;
	logic [dpr_pkg::StepW-1:0]  cur_step       = dpr_pkg::RstStep;
	logic [dpr_pkg::DepthW-1:0] cur_min_depth  = dpr_pkg::RstMinDepth;
	logic [dpr_pkg::DepthW-1:0] cur_max_depth  = dpr_pkg::RstMaxDepth;
	logic [dpr_pkg::InvW-1:0]   cur_inv_x      = dpr_pkg::RstInvFocal;
	logic [dpr_pkg::InvW-1:0]   cur_inv_y      = dpr_pkg::RstInvFocal;

	// raster position of the next raw pixel
	logic [dpr_pkg::PhaseW-1:0] pos_col_phase = '0;
	logic [dpr_pkg::IndexW-1:0] pos_col_index = '0;
	logic [dpr_pkg::PhaseW-1:0] pos_row_phase = '0;
	logic [dpr_pkg::IndexW-1:0] pos_row_index = '0;

	depth_to_point_reprojection_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.depth_mm      (depth_mm),
		.frame_start   (frame_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.x_sixteenth_mm(x_sixteenth_mm),
		.y_sixteenth_mm(y_sixteenth_mm),
		.z_mm          (z_mm),
		.point_valid   (point_valid),
		.frame_end     (frame_end)
	);

	always #4 clk = ~clk;

	function automatic int clamp_to(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// floor of offset * depth * inv_focal / 2^21, saturated to 32 bits signed
	function automatic logic signed [31:0] backproject(input int offset,
			input logic [dpr_pkg::DepthW-1:0] depth,
			input logic [dpr_pkg::InvW-1:0] inv_focal);
		logic [63:0] mag;
		logic [63:0] prod;
		logic [63:0] q;
		mag = (offset < 0) ? 64'(-offset) : 64'(offset);
		prod = mag * 64'(depth) * 64'(inv_focal);
		if (offset >= 0) begin
			q = prod >> dpr_pkg::FracShift;
			if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
			return q[31:0];
		end
		q = (prod + ((64'd1 << dpr_pkg::FracShift) - 64'd1)) >> dpr_pkg::FracShift;
		if (q > 64'h8000_0000) q = 64'h8000_0000;
		return 32'(64'h1_0000_0000 - q);
	endfunction

	// one raw pixel through the downsampler and the pinhole back-projection
	function automatic bit reproject_pixel(input pixel_t pix, output point_t pt);
		int w;
		int h;
		int s;
		bit col_end_ph;
		bit col_end;
		bit row_end_ph;
		bit row_end;
		bit last_px;
		bit kept;
		bit hit;
		w = clamp_to(int'(cur_out_width), 1, int'(dpr_pkg::MaxOutWidth));
		h = clamp_to(int'(cur_out_height), 1, int'(dpr_pkg::MaxOutHeight));
		s = clamp_to(int'(cur_step), 1, int'(dpr_pkg::MaxStep));
		if (pix.start) begin
			pos_col_phase = '0;
			pos_col_index = '0;
			pos_row_phase = '0;
			pos_row_index = '0;
		end
		col_end_ph = int'(pos_col_phase) >= s - 1;
		col_end    = int'(pos_col_index) >= w - 1;
		row_end_ph = int'(pos_row_phase) >= s - 1;
		row_end    = int'(pos_row_index) >= h - 1;
		last_px = col_end_ph && col_end && row_end_ph && row_end;
		kept = (pos_col_phase == '0) && (pos_row_phase == '0);
		hit = kept && (pix.depth > cur_min_depth) && (pix.depth < cur_max_depth);
		pt = '0;
		if (hit) begin
			pt.x = backproject(2 * int'(pos_col_index) - w, pix.depth, cur_inv_x);
			pt.y = backproject(2 * int'(pos_row_index) - h, pix.depth, cur_inv_y);
			pt.z = pix.depth;
		end
		pt.point_valid = hit;
		pt.frame_end = last_px;
		// advance the raster position
		if (!col_end_ph) begin
			pos_col_phase = pos_col_phase + dpr_pkg::PhaseW'(1);
		end else begin
			pos_col_phase = '0;
			if (!col_end) begin
				pos_col_index = pos_col_index + dpr_pkg::IndexW'(1);
			end else begin
				pos_col_index = '0;
				if (!row_end_ph) begin
					pos_row_phase = pos_row_phase + dpr_pkg::PhaseW'(1);
				end else begin
					pos_row_phase = '0;
					if (!row_end) pos_row_index = pos_row_index + dpr_pkg::IndexW'(1);
					else pos_row_index = '0;
				end
			end
		end
		return hit || last_px;
	endfunction

	function automatic int raw_frame_pixels();
		int w;
		int h;
		int s;
		w = clamp_to(int'(cur_out_width), 1, int'(dpr_pkg::MaxOutWidth));
		h = clamp_to(int'(cur_out_height), 1, int'(dpr_pkg::MaxOutHeight));
		s = clamp_to(int'(cur_step), 1, int'(dpr_pkg::MaxStep));
		return w * s * h * s;
	endfunction

	// mostly in-range depths, with zeros, full scale and anything at all mixed in
	function automatic logic [dpr_pkg::DepthW-1:0] pick_depth();
		int lo;
		int hi;
		lo = int'(cur_min_depth) + 1;
		hi = int'(cur_max_depth) - 1;
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2, 3: begin
				return dpr_pkg::DepthW'($urandom);
			end
			default: begin
				if (hi >= lo) return dpr_pkg::DepthW'($urandom_range(lo, hi));
				return dpr_pkg::DepthW'($urandom);
			end
		endcase
	endfunction

	task automatic push_pixel(input int depth, input bit start);
		pixel_t pix;
		pix.depth = dpr_pkg::DepthW'(depth);
		pix.start = start;
		pixel_q.insert(pixel_q.size(), pix);
	endtask

	// register write; the enable stays high until finish_writes
	task automatic write_reg(input logic [2:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= dpr_pkg::CfgDataW'(val);
		case (idx)
			dpr_pkg::REG_OUT_WIDTH:    cur_out_width  = dpr_pkg::SizeW'(val);
			dpr_pkg::REG_OUT_HEIGHT:   cur_out_height = dpr_pkg::SizeW'(val);
			dpr_pkg::REG_STEP:         cur_step       = dpr_pkg::StepW'(val);
			dpr_pkg::REG_MIN_DEPTH_MM: cur_min_depth  = dpr_pkg::DepthW'(val);
			dpr_pkg::REG_MAX_DEPTH_MM: cur_max_depth  = dpr_pkg::DepthW'(val);
			dpr_pkg::REG_INV_FOCAL_X:  cur_inv_x      = dpr_pkg::InvW'(val);
			dpr_pkg::REG_INV_FOCAL_Y:  cur_inv_y      = dpr_pkg::InvW'(val);
			default: ;
		endcase
	endtask

	task automatic finish_writes();
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic apply_setting(input int unsigned w, input int unsigned h,
			input int unsigned s, input int unsigned mn, input int unsigned mx,
			input int unsigned ix, input int unsigned iy);
		write_reg(dpr_pkg::REG_OUT_WIDTH, w);
		write_reg(dpr_pkg::REG_OUT_HEIGHT, h);
		write_reg(dpr_pkg::REG_STEP, s);
		write_reg(dpr_pkg::REG_MIN_DEPTH_MM, mn);
		write_reg(dpr_pkg::REG_MAX_DEPTH_MM, mx);
		write_reg(dpr_pkg::REG_INV_FOCAL_X, ix);
		write_reg(dpr_pkg::REG_INV_FOCAL_Y, iy);
		finish_writes();
	endtask

	task automatic set_traffic(input int mode);
		case (mode)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 53; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 53; end
			default: begin gap_pct = 38; stall_pct = 38; end
		endcase
	endtask

	// wait for every pixel and point to pass, then for any dropped pixel in flight
	task automatic settle();
		while (pixel_q.size() != 0 || in_valid || pending_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected 0x%08h actual 0x%08h",
				$time, name, want, got);
			mismatch_count++;
		end
	endtask

	// driver: pixel transactions and receiver back-pressure, changed on the falling edge
	always @(negedge clk) begin : driver
		pixel_t pix;
		if (arst_n && (!in_valid || pixel_taken)) begin
			if (pixel_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
				pix = pixel_q.pop_front();
				in_valid    <= 1'b1;
				depth_mm    <= pix.depth;
				frame_start <= pix.start;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
	end

	// monitor: check each result transaction, then predict from each pixel transaction
	always @(posedge clk) begin : monitor
		point_t want_pt;
		point_t got_pt;
		pixel_t pix;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got_pt = {x_sixteenth_mm, y_sixteenth_mm, z_mm, point_valid, frame_end};
				if (pending_points.size() == 0) begin
					$display("%0t ns: unexpected result, expected none actual %h",
						$time, got_pt);
					mismatch_count++;
				end else begin
					want_pt = pending_points.pop_front();
					compare_field("x_sixteenth_mm", want_pt.x, got_pt.x);
					compare_field("y_sixteenth_mm", want_pt.y, got_pt.y);
					compare_field("z_mm", 32'(want_pt.z), 32'(got_pt.z));
					compare_field("point_valid", 32'(want_pt.point_valid),
						32'(got_pt.point_valid));
					compare_field("frame_end", 32'(want_pt.frame_end),
						32'(got_pt.frame_end));
				end
			end
			if (in_valid && in_ready) begin
				pix.depth = depth_mm;
				pix.start = frame_start;
				if (reproject_pixel(pix, want_pt))
					pending_points.insert(pending_points.size(), want_pt);
			end
			pixel_taken <= in_valid && in_ready;
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int count;
		int kind;
		int len;
		int w;
		int h;
		int s;
		int mn;
		int mx;
		int ix;
		int iy;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// two by one frame at step two: depth limits, dropped pixels, wrap and restart
		set_traffic(0);
		apply_setting(2, 1, 2, 100, 200, 67109, 0);
		push_pixel(150, 1);
		push_pixel(65535, 0);
		push_pixel(100, 0);
		push_pixel(0, 0);
		push_pixel(199, 0);
		push_pixel(199, 0);
		push_pixel(199, 0);
		push_pixel(150, 0);
		push_pixel(200, 0);
		push_pixel(50, 0);
		push_pixel(199, 1);
		push_pixel(101, 0);
		push_pixel(101, 0);
		settle();

		// single-pixel frames: frame end with and without a point
		apply_setting(1, 1, 1, 0, 65535, 32'h100_0000, 32'h1FF_FFFF);
		push_pixel(65535, 1);
		push_pixel(1, 0);
		settle();

		// widest frame, clamped height and step, negative saturation
		apply_setting(4096, 8191, 0, 0, 65535, 32'h1FF_FFFF, 32'h100_0000);
		push_pixel(65534, 1);
		push_pixel(1, 0);
		settle();

		// width shrunk mid-row leaves the column counter past its limit
		apply_setting(8, 2, 1, 0, 65535, $urandom_range(0, 32'h1FF_FFFF),
			$urandom_range(0, 32'h1FF_FFFF));
		for (int i = 0; i < 4; i++) push_pixel($urandom_range(1, 65534), i == 0);
		settle();
		write_reg(dpr_pkg::REG_OUT_WIDTH, 2);
		finish_writes();
		for (int i = 0; i < 3; i++) push_pixel($urandom_range(1, 65534), 0);
		settle();

		// one full row: sparse points, large positive offsets near the far edge
		set_traffic(3);
		apply_setting(WIDE_ROW_PIXELS, 1, 1, 0, 65535, 32'h1FF_FFFF,
			$urandom_range(0, 32'h1FF_FFFF));
		for (int u = 0; u < WIDE_ROW_PIXELS; u++) begin
			if (u == WIDE_ROW_PIXELS - 1 || (u >= 180 && u % 8 == 0))
				push_pixel($urandom_range(60000, 65534), u == 0);
			else if (u % 53 == 0)
				push_pixel($urandom, u == 0);
			else
				push_pixel(0, u == 0);
		end
		settle();

		// random settings with mostly complete frames of random content
		for (int p = 0; p < RAND_PHASES; p++) begin
			set_traffic(p % 4);
			case ($urandom_range(0, 5))
				0: w = 0;
				1: w = 1;
				default: w = $urandom_range(2, 6);
			endcase
			case ($urandom_range(0, 4))
				0: h = 0;
				1: h = 1;
				default: h = $urandom_range(2, 4);
			endcase
			case ($urandom_range(0, 5))
				0: s = 0;
				1: s = 31;
				default: s = $urandom_range(1, 3);
			endcase
			// keep the largest step to one-by-one frames
			if (s == 31) begin
				w = 1;
				h = 1;
			end
			case ($urandom_range(0, 5))
				0: begin mn = 0; mx = 65535; end
				1: begin mn = $urandom_range(0, 65535); mx = $urandom_range(0, 65535); end
				2: begin mn = 65535; mx = 0; end
				default: begin
					mn = $urandom_range(0, 1000);
					mx = mn + $urandom_range(2, 5000);
				end
			endcase
			case ($urandom_range(0, 5))
				0: ix = 32'h1FF_FFFF;
				1: ix = 0;
				2: ix = 32'h100_0000;
				3: ix = $urandom_range(0, 32'h1FF_FFFF);
				default: ix = $urandom_range(30000, 200000);
			endcase
			case ($urandom_range(0, 5))
				0: iy = 32'h1FF_FFFF;
				1: iy = 0;
				2: iy = 32'h100_0000;
				3: iy = $urandom_range(0, 32'h1FF_FFFF);
				default: iy = $urandom_range(30000, 200000);
			endcase
			apply_setting(w, h, s, mn, mx, ix, iy);
			count = 0;
			while (count < RAND_ITEMS_PER_PHASE) begin
				kind = $urandom_range(0, 9);
				len = raw_frame_pixels();
				// truncated frames now and then
				if (kind >= 8) len = $urandom_range(1, len);
				for (int i = 0; i < len; i++) begin
					if (i == 0) push_pixel(pick_depth(), kind != 0);
					else push_pixel(pick_depth(), $urandom_range(0, 199) == 0);
				end
				count += len;
			end
			settle();
		end

		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
